// ----- design/assert_macros.svh -----
// Assertion macros shared by the queue buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at each clock edge outside reset.
`define MQSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every clock edge, reset included.
`define MQSB_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MQSB_ASSERT(label, clk, rst, prop, msg)
`define MQSB_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ----- design/mqsb_pkg.sv -----
// Types and constants shared by the queue buffer modules.
package mqsb_pkg;

   // Fixed field widths of the request and result channels.
   localparam int CMD_W    = 1;
   localparam int QID_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // capture the request and read the memories
      logic commit;   // update the queue state and load the result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy; // result register full and not taken this cycle
   } dp_status_type;

endpackage

// ----- design/mqsb_channels.sv -----
// Request and result channel interfaces of the queue buffer.
interface mqsb_req_if;
   logic                              valid;
   logic                              ready;
   logic [mqsb_pkg::CMD_W-1:0]        cmd;
   logic [mqsb_pkg::QID_W-1:0]        queue_id;
   logic signed [mqsb_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, cmd, queue_id, push_value, input ready);
   modport sink   (input valid, cmd, queue_id, push_value, output ready);
endinterface

interface mqsb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mqsb_pkg::VALUE_W-1:0] pop_value;
   logic [mqsb_pkg::STATUS_W-1:0]       status;

   modport source (output valid, pop_value, status, input ready);
   modport sink   (input valid, pop_value, status, output ready);
endinterface

// ----- design/mqsb_controller.sv -----
// Sequencing state machine of the queue buffer.
`include "assert_macros.svh"

module mqsb_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output mqsb_pkg::dp_cmd_type    dp_cmd,
   input  mqsb_pkg::dp_status_type dp_status
);

   mqsb_pkg::ctl_state_type state_ff;
   mqsb_pkg::ctl_state_type state_in;

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqsb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: take a request, then wait for room in the result register
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqsb_pkg::ST_IDLE: begin
            if (req_valid) state_in = mqsb_pkg::ST_EXEC;
         end
         mqsb_pkg::ST_EXEC: begin
            if (!dp_status.out_busy) state_in = mqsb_pkg::ST_IDLE;
         end
         default: state_in = mqsb_pkg::ST_IDLE;
      endcase
   end

   // Outputs: ready while idle, commit once the result register has room
   always_comb begin
      req_ready     = 1'b0;
      dp_cmd.start  = 1'b0;
      dp_cmd.commit = 1'b0;
      unique case (state_ff)
         mqsb_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            dp_cmd.start = req_valid;
         end
         mqsb_pkg::ST_EXEC: begin
            dp_cmd.commit = !dp_status.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `MQSB_ASSERT(a_accept_enters_exec, clock, reset, (state_ff == mqsb_pkg::ST_IDLE && req_valid) |=> (state_ff == mqsb_pkg::ST_EXEC), "accepted request did not enter execute")
   `MQSB_ASSERT_NR(a_reset_to_idle, clock, reset |=> (state_ff == mqsb_pkg::ST_IDLE), "controller not idle after reset")

endmodule

// ----- design/mqsb_datapath.sv -----
// Queue pointers, link and data memories, and result register.
`include "assert_macros.svh"

module mqsb_datapath #(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mqsb_pkg::dp_cmd_type                dp_cmd,
   output mqsb_pkg::dp_status_type             dp_status,
   input  logic [mqsb_pkg::CMD_W-1:0]          req_cmd,
   input  logic [mqsb_pkg::QID_W-1:0]          req_queue_id,
   input  logic signed [mqsb_pkg::VALUE_W-1:0] req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mqsb_pkg::VALUE_W-1:0] rsp_pop_value,
   output logic [mqsb_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int PTR_W  = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int Q_W    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int QX_W   = (Q_W > mqsb_pkg::QID_W) ? Q_W : mqsb_pkg::QID_W;
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);

   // Queue state
   logic [PTR_W-1:0]  head_ff [QUEUES];
   logic [PTR_W-1:0]  head_in [QUEUES];
   logic [PTR_W-1:0]  tail_ff [QUEUES];
   logic [PTR_W-1:0]  tail_in [QUEUES];
   logic [QUEUES-1:0] nonempty_ff;
   logic [QUEUES-1:0] nonempty_in;
   logic [LINK_W-1:0] free_head_ff;
   logic [LINK_W-1:0] free_head_in;
   // Slots at or above the fill count have never been linked; their link is taken as index + 1
   logic [LINK_W-1:0] fill_ff;
   logic [LINK_W-1:0] fill_in;

   // Memories
   logic [LINK_W-1:0]                  link_mem [SLOTS];
   logic signed [mqsb_pkg::VALUE_W-1:0] data_mem [SLOTS];

   // Captured request and read results
   logic [mqsb_pkg::CMD_W-1:0]          cmd_ff;
   logic [Q_W-1:0]                      qidx_ff;
   logic signed [mqsb_pkg::VALUE_W-1:0] value_ff;
   logic [PTR_W-1:0]                    slot_ff;
   logic                                ok_ff;
   logic                                fresh_ff;
   logic [LINK_W-1:0]                   link_rd_ff;
   logic signed [mqsb_pkg::VALUE_W-1:0] data_rd_ff;

   // Result register
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [mqsb_pkg::VALUE_W-1:0] pop_value_ff;
   logic signed [mqsb_pkg::VALUE_W-1:0] pop_value_in;
   logic [mqsb_pkg::STATUS_W-1:0]       status_ff;
   logic [mqsb_pkg::STATUS_W-1:0]       status_in;

   // Request decode
   logic [QX_W-1:0]  req_q_ext;
   logic             req_in_range;
   logic [Q_W-1:0]   req_qidx;
   logic [PTR_W-1:0] slot_sel;
   logic             ok_sel;

   // Write ports
   logic              link_we;
   logic [PTR_W-1:0]  link_waddr;
   logic [LINK_W-1:0] link_wdata;
   logic              data_we;
   logic [LINK_W-1:0] next_free;

   assign req_q_ext    = QX_W'(req_queue_id);
   assign req_in_range = {1'b0, req_q_ext} < (QX_W + 1)'(QUEUES);
   assign req_qidx     = req_q_ext[Q_W-1:0];

   // Pick the slot this request touches: free head for push, queue head for pop
   always_comb begin
      slot_sel = '0;
      ok_sel   = 1'b0;
      if (req_cmd == mqsb_pkg::CMD_PUSH) begin
         slot_sel = free_head_ff[PTR_W-1:0];
         ok_sel   = req_in_range && (free_head_ff != END_MARK);
      end else if (req_in_range) begin
         slot_sel = head_ff[req_qidx];
         ok_sel   = nonempty_ff[req_qidx];
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (dp_cmd.start) begin
         cmd_ff   <= req_cmd;
         qidx_ff  <= req_qidx;
         value_ff <= req_push_value;
         slot_ff  <= slot_sel;
         ok_ff    <= ok_sel;
         fresh_ff <= LINK_W'(slot_sel) >= fill_ff;
      end
   end

   // Read both memories at the selected slot
   always_ff @(posedge clock) begin
      if (dp_cmd.start) begin
         link_rd_ff <= link_mem[slot_sel];
         data_rd_ff <= data_mem[slot_sel];
      end
   end

   assign next_free = fresh_ff ? (LINK_W'(slot_ff) + LINK_W'(1)) : link_rd_ff;

   // Commit: relink the slot and build the result
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      link_we      = 1'b0;
      link_waddr   = slot_ff;
      link_wdata   = free_head_ff;
      data_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      pop_value_in = pop_value_ff;
      status_in    = status_ff;
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (cmd_ff == mqsb_pkg::CMD_PUSH) begin
            pop_value_in = '0;
            if (ok_ff) begin
               status_in    = mqsb_pkg::STATUS_OK;
               free_head_in = next_free;
               if (nonempty_ff[qidx_ff]) begin
                  // append behind the current tail
                  link_we    = 1'b1;
                  link_waddr = tail_ff[qidx_ff];
                  link_wdata = LINK_W'(slot_ff);
               end else begin
                  head_in[qidx_ff] = slot_ff;
               end
               nonempty_in[qidx_ff] = 1'b1;
               tail_in[qidx_ff]     = slot_ff;
               data_we              = 1'b1;
               if (fresh_ff) fill_in = fill_ff + LINK_W'(1);
            end else begin
               status_in = mqsb_pkg::STATUS_OVER;
            end
         end else begin
            if (ok_ff) begin
               status_in    = mqsb_pkg::STATUS_OK;
               pop_value_in = data_rd_ff;
               // the last slot of a queue is its tail
               if (slot_ff == tail_ff[qidx_ff]) begin
                  nonempty_in[qidx_ff] = 1'b0;
               end else begin
                  head_in[qidx_ff] = link_rd_ff[PTR_W-1:0];
               end
               // push the slot onto the front of the free list
               link_we      = 1'b1;
               link_waddr   = slot_ff;
               link_wdata   = free_head_ff;
               free_head_in = LINK_W'(slot_ff);
            end else begin
               status_in    = mqsb_pkg::STATUS_UNDER;
               pop_value_in = '1;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the queue state and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         nonempty_ff  <= '0;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nonempty_ff  <= nonempty_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      pop_value_ff <= pop_value_in;
      status_ff    <= status_in;
   end

   // Write the memories
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (data_we) data_mem[slot_ff] <= value_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pop_value      = pop_value_ff;
   assign rsp_status         = status_ff;
   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;

   `MQSB_ASSERT(a_free_empty_all_used, clock, reset, (free_head_ff == END_MARK) |-> (fill_ff == END_MARK), "free list empty with untouched slots left")
   `MQSB_ASSERT(a_fresh_at_fill, clock, reset, (dp_cmd.commit && cmd_ff == mqsb_pkg::CMD_PUSH && ok_ff && fresh_ff) |-> (LINK_W'(slot_ff) == fill_ff), "untouched slot taken out of order")
   `MQSB_ASSERT(a_push_ok_result, clock, reset, (dp_cmd.commit && cmd_ff == mqsb_pkg::CMD_PUSH && ok_ff) |=> (rsp_valid_ff && status_ff == mqsb_pkg::STATUS_OK), "accepted push did not report ok")
   `MQSB_ASSERT(a_pop_under_result, clock, reset, (dp_cmd.commit && cmd_ff == mqsb_pkg::CMD_POP && !ok_ff) |=> (status_ff == mqsb_pkg::STATUS_UNDER && pop_value_ff == '1), "failed pop did not report underflow")

endmodule

// ----- design/multi_queue_shared_buffer_core.sv -----
// Top level of the shared-buffer multi-queue: QUEUES FIFOs chained through one slot store.
// Each request (push or pop) is accepted while the block is idle and yields one result: the
// block first reads the link and data memories at the selected slot (free list head for a
// push, queue head for a pop), then relinks the slot and loads the result register. Only
// then does the block take the next request, as the link memory read is registered. A new
// request is accepted while an earlier result still waits in the result register; the update
// stalls only when that register is still full and not taken. Untouched slots are tracked by
// a fill count, so the link memory needs no clearing pass after reset and the block is ready
// at once.
module multi_queue_shared_buffer_core #(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 4
) (
   input logic        clock,
   input logic        reset,
   mqsb_req_if.sink   req_chan,
   mqsb_rsp_if.source rsp_chan
);

   mqsb_pkg::dp_cmd_type    dp_cmd;
   mqsb_pkg::dp_status_type dp_status;

   // Sequence each request
   mqsb_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // Queue state, memories and result register
   mqsb_datapath #(
      .SLOTS  (SLOTS),
      .QUEUES (QUEUES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_chan.cmd),
      .req_queue_id   (req_chan.queue_id),
      .req_push_value (req_chan.push_value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_pop_value  (rsp_chan.pop_value),
      .rsp_status     (rsp_chan.status)
   );

endmodule

// ----- tb/tb_multi_queue_shared_buffer_core.sv -----
// Self-checking testbench of the shared-buffer multi-queue: directed and random push/pop traffic.
module tb_multi_queue_shared_buffer_core;

   localparam int SLOTS      = 64;
   localparam int QUEUES     = 4;
   localparam int LINK_W     = 7;
   localparam int PTR_W      = 6;
   localparam int RUN_LIMIT  = 2000000;
   localparam int TAIL_WAIT  = 20;

   typedef struct packed {
      logic signed [mqsb_pkg::VALUE_W-1:0] pop_value;
      logic [mqsb_pkg::STATUS_W-1:0]       status;
   } queue_result_type;

   logic clock;
   logic reset;

   mqsb_req_if req ();
   mqsb_rsp_if rsp ();

   multi_queue_shared_buffer_core #(
      .SLOTS  (SLOTS),
      .QUEUES (QUEUES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // Shadow copy of the linked-list buffer.
   logic [PTR_W-1:0]             shadow_head [QUEUES];
   logic [PTR_W-1:0]             shadow_tail [QUEUES];
   logic                         shadow_busy [QUEUES];
   logic [LINK_W-1:0]            shadow_link [SLOTS];
   logic [LINK_W-1:0]            shadow_free;
   logic [mqsb_pkg::VALUE_W-1:0] shadow_data [SLOTS];

   queue_result_type pending_results [$];
   int               error_count = 0;

   // Traffic shaping knobs.
   int        gap_max     = 0;
   int        burst_left  = 0;
   logic      rsp_stall_on = 1'b0;
   logic [15:0] stall_pattern = 16'hffff;
   logic [3:0]  pattern_pos   = 4'd0;

   // Toggle the clock: 4 high, 4 low.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bring the shadow buffer to its reset state.
   task automatic shadow_reset();
      for (int q = 0; q < QUEUES; q++) begin
         shadow_head[q] = '0;
         shadow_tail[q] = '0;
         shadow_busy[q] = 1'b0;
      end
      for (int s = 0; s < SLOTS; s++) begin
         shadow_link[s] = LINK_W'(s + 1);
         shadow_data[s] = '0;
      end
      shadow_free = '0;
   endtask

   // Apply one request to the shadow buffer and return the result it gives.
   function automatic queue_result_type buffer_apply(
         input logic [mqsb_pkg::CMD_W-1:0]   op,
         input logic [mqsb_pkg::QID_W-1:0]   qid,
         input logic [mqsb_pkg::VALUE_W-1:0] value);
      queue_result_type  res;
      logic [LINK_W-1:0] slot;
      logic [LINK_W-1:0] next;
      logic [PTR_W-1:0]  idx;
      if (op == mqsb_pkg::CMD_PUSH) begin
         res.pop_value = '0;
         slot = shadow_free;
         if (qid >= QUEUES || slot >= SLOTS) begin
            res.status = mqsb_pkg::STATUS_OVER;
            return res;
         end
         idx = slot[PTR_W-1:0];
         shadow_free = shadow_link[idx];
         if (shadow_busy[qid])
            shadow_link[shadow_tail[qid]] = slot;
         else
            shadow_head[qid] = idx;
         shadow_busy[qid] = 1'b1;
         shadow_link[idx] = LINK_W'(SLOTS);
         shadow_tail[qid] = idx;
         shadow_data[idx] = value;
         res.status = mqsb_pkg::STATUS_OK;
         return res;
      end
      // Pop: unlink the head slot and put it at the front of the free list.
      if (qid >= QUEUES || !shadow_busy[qid]) begin
         res.pop_value = -1;
         res.status = mqsb_pkg::STATUS_UNDER;
         return res;
      end
      idx  = shadow_head[qid];
      slot = {1'b0, idx};
      next = shadow_link[idx];
      if (next >= SLOTS)
         shadow_busy[qid] = 1'b0;
      shadow_head[qid] = next[PTR_W-1:0];
      shadow_link[idx] = shadow_free;
      shadow_free = slot;
      res.pop_value = shadow_data[idx];
      res.status = mqsb_pkg::STATUS_OK;
      return res;
   endfunction

   // Send one request in bursts with random gaps, and record its expected result.
   task automatic send_request(input logic [mqsb_pkg::CMD_W-1:0] op,
                               input logic [mqsb_pkg::QID_W-1:0] qid,
                               input logic [mqsb_pkg::VALUE_W-1:0] value);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if (gap_max > 0)
            gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req.valid      <= 1'b1;
      req.cmd        <= op;
      req.queue_id   <= qid;
      req.push_value <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_results.push_back(buffer_apply(op, qid, value));
      @(negedge clock);
   endtask

   // Hold the sender idle until every expected result has come back.
   task automatic wait_results_drained();
      req.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Pick a data word, favoring the extremes now and then.
   function automatic logic [mqsb_pkg::VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Issue random pushes and pops; focus_q < 0 spreads them over all queues.
   task automatic run_random_phase(input int count, input int push_pct, input int focus_q);
      logic [mqsb_pkg::CMD_W-1:0] op;
      logic [mqsb_pkg::QID_W-1:0] qid;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < push_pct) ? mqsb_pkg::CMD_PUSH : mqsb_pkg::CMD_POP;
         if (focus_q >= 0 && $urandom_range(0, 3) != 0)
            qid = mqsb_pkg::QID_W'(focus_q);
         else
            qid = mqsb_pkg::QID_W'($urandom_range(0, QUEUES - 1));
         send_request(op, qid, pick_word());
      end
   endtask

   // Pop every queue right after reset: all must underflow.
   task automatic test_empty_pops();
      for (int q = 0; q < QUEUES; q++)
         send_request(mqsb_pkg::CMD_POP, mqsb_pkg::QID_W'(q), $urandom());
      wait_results_drained();
   endtask

   // Push extreme words, empty a queue, then reuse it through its stale tail.
   task automatic test_value_extremes();
      send_request(mqsb_pkg::CMD_PUSH, 2'd0, 32'h8000_0000);
      send_request(mqsb_pkg::CMD_PUSH, 2'd0, 32'h7fff_ffff);
      send_request(mqsb_pkg::CMD_PUSH, 2'd1, 32'h0000_0000);
      send_request(mqsb_pkg::CMD_PUSH, 2'd3, 32'hffff_ffff);
      send_request(mqsb_pkg::CMD_PUSH, 2'd2, 32'h5555_5555);
      send_request(mqsb_pkg::CMD_PUSH, 2'd2, 32'haaaa_aaaa);
      send_request(mqsb_pkg::CMD_POP,  2'd0, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd0, 32'hffff_ffff);
      send_request(mqsb_pkg::CMD_POP,  2'd0, 32'h0);
      send_request(mqsb_pkg::CMD_PUSH, 2'd0, 32'h1234_5678);
      send_request(mqsb_pkg::CMD_PUSH, 2'd0, 32'hedcb_a987);
      send_request(mqsb_pkg::CMD_POP,  2'd1, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd3, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd2, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd2, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd0, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd0, 32'h0);
      send_request(mqsb_pkg::CMD_POP,  2'd1, 32'h0);
      wait_results_drained();
   endtask

   // Fill the buffer past overflow and drain it past underflow under each idle mix.
   task automatic test_fill_and_drain();
      for (int round = 0; round < 4; round++) begin
         gap_max      = (round[0]) ? 6 : 0;
         rsp_stall_on = round[1];
         run_random_phase(150, 80, -1);
         wait_results_drained();
         run_random_phase(150, 20, -1);
         wait_results_drained();
      end
   endtask

   // Work mostly one queue at a time with both sides idling.
   task automatic test_single_queue();
      gap_max      = 4;
      rsp_stall_on = 1'b1;
      for (int q = 0; q < QUEUES; q++) begin
         run_random_phase(25, 65, q);
         run_random_phase(15, 35, q);
      end
      wait_results_drained();
   endtask

   // Stall the receiver on a random 16-bit pattern, refreshed each period.
   initial rsp.ready = 1'b0;
   always @(negedge clock) begin
      pattern_pos <= pattern_pos + 4'd1;
      if (pattern_pos == 4'd15)
         stall_pattern <= 16'($urandom()) | 16'h0001;
      rsp.ready <= !rsp_stall_on || stall_pattern[pattern_pos];
   end

   // Compare each taken result with the oldest expectation.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: pop_value %0d status %0d", rsp.pop_value, rsp.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.pop_value !== want.pop_value) begin
               $error("pop_value: expected %0d, actual %0d", want.pop_value, rsp.pop_value);
               error_count++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp.status);
               error_count++;
            end
         end
      end
   end

   // Bound the run time.
   initial begin
      #(RUN_LIMIT);
      $display("** multi_queue_shared_buffer_core: FAILED **");
      $finish;
   end

   // Reset, run each test in turn, then report.
   initial begin
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.cmd        = mqsb_pkg::CMD_PUSH;
      req.queue_id   = '0;
      req.push_value = '0;
      shadow_reset();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_max      = 3;
      rsp_stall_on = 1'b1;
      test_empty_pops();
      test_value_extremes();
      test_fill_and_drain();
      test_single_queue();

      wait_results_drained();
      repeat (TAIL_WAIT) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("** multi_queue_shared_buffer_core: PASSED **");
      else
         $display("** multi_queue_shared_buffer_core: FAILED **");
      $finish;
   end

endmodule
